### rtl/core/fmm_pkg.sv
package fmm_pkg;

    localparam int DEF_MATRIX_SIZE = 8;
    localparam int IDX_W           = 3;
    localparam int STORE_DEPTH     = 64;
    localparam int STORE_AW        = 6;
    localparam int FP_W            = 32;
    localparam int LANE_W          = 2;

    localparam logic [1:0]      CMD_LOAD_A  = 2'd0;
    localparam logic [1:0]      CMD_LOAD_B  = 2'd1;
    localparam logic [1:0]      CMD_COMPUTE = 2'd2;
    localparam logic [FP_W-1:0] CANON_NAN   = 32'h7FC0_0000;

    // value = mant / 2^47 * 2^(exp - 127)
    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        mant;
    } fmm_ifp_t;

    // operands of an add after alignment
    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               inf_sign;
        logic               sign_hi;
        logic               sign_and;
        logic               sub;
        logic signed [10:0] exp;
        logic [47:0]        hi_m;
        logic [47:0]        lo_m;
    } fmm_aln_t;

    // controller to datapath
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [IDX_W-1:0]  ri;
        logic [IDX_W-1:0]  rj;
        logic [IDX_W-1:0]  k;
        logic [LANE_W-1:0] lane;
        logic              fin;
        logic              fin_first;
        logic              nsel_sum;
        logic              wr_prod;
        logic              wr_lane;
        logic              wr_acc;
        logic              clr;
        logic              emit;
        logic              last;
    } fmm_cmd_t;

    typedef struct packed {
        logic out_busy;
    } fmm_sts_t;

    function automatic logic fp_is_nan(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    // exact product, rounding happens later
    function automatic fmm_ifp_t fp_mul(logic [31:0] a, logic [31:0] b);
        fmm_ifp_t           r;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic signed [10:0] ea;
        logic signed [10:0] eb;
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        ea = (a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, a[30:23]});
        eb = (b[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, b[30:23]});
        r.sign = a[31] ^ b[31];
        r.nan  = fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_zero(b))
                 || (fp_is_zero(a) && fp_is_inf(b));
        r.inf  = fp_is_inf(a) || fp_is_inf(b);
        r.exp  = ea + eb - 11'sd126;
        r.mant = ma * mb;
        return r;
    endfunction

    function automatic fmm_aln_t fp_align(logic [31:0] x, logic [31:0] y);
        fmm_aln_t           r;
        logic [23:0]        mx;
        logic [23:0]        my;
        logic [10:0]        ex;
        logic [10:0]        ey;
        logic               x_hi;
        logic [23:0]        mh;
        logic [23:0]        ml;
        logic [10:0]        eh;
        logic [10:0]        el;
        logic [10:0]        d;
        logic [47:0]        lo_f;
        logic               st;
        mx   = {(x[30:23] != 8'd0), x[22:0]};
        my   = {(y[30:23] != 8'd0), y[22:0]};
        ex   = (x[30:23] == 8'd0) ? 11'd1 : {3'b000, x[30:23]};
        ey   = (y[30:23] == 8'd0) ? 11'd1 : {3'b000, y[30:23]};
        x_hi = (ex > ey) || ((ex == ey) && (mx >= my));
        mh   = x_hi ? mx : my;
        ml   = x_hi ? my : mx;
        eh   = x_hi ? ex : ey;
        el   = x_hi ? ey : ex;
        d    = eh - el;
        lo_f = {1'b0, ml, 23'd0};
        if (d >= 11'd48) begin
            st   = |ml;
            lo_f = 48'd0;
        end else begin
            st   = |(lo_f & ~({48{1'b1}} << d));
            lo_f = lo_f >> d;
        end
        r.nan      = fp_is_nan(x) || fp_is_nan(y)
                     || (fp_is_inf(x) && fp_is_inf(y) && (x[31] != y[31]));
        r.inf      = fp_is_inf(x) || fp_is_inf(y);
        r.inf_sign = fp_is_inf(x) ? x[31] : y[31];
        r.sign_hi  = x_hi ? x[31] : y[31];
        r.sign_and = x[31] & y[31];
        r.sub      = x[31] ^ y[31];
        r.exp      = $signed(eh) + 11'sd1;
        r.hi_m     = {1'b0, mh, 23'd0};
        r.lo_m     = {lo_f[47:1], lo_f[0] | st};
        return r;
    endfunction

    function automatic fmm_ifp_t fp_sum(fmm_aln_t a);
        fmm_ifp_t r;
        logic [47:0] s;
        s      = a.sub ? (a.hi_m - a.lo_m) : (a.hi_m + a.lo_m);
        r.nan  = a.nan;
        r.inf  = a.inf;
        r.exp  = a.exp;
        r.mant = s;
        if (a.inf) begin
            r.sign = a.inf_sign;
        end else if (s == 48'd0) begin
            r.sign = a.sign_and;
        end else begin
            r.sign = a.sign_hi;
        end
        return r;
    endfunction

    // leading one to bit 47
    function automatic fmm_ifp_t fp_norm(fmm_ifp_t v);
        fmm_ifp_t    r;
        logic [5:0]  lz;
        logic        found;
        lz    = 6'd0;
        found = 1'b0;
        for (int b = 47; b >= 0; b--) begin
            if (!found) begin
                if (v.mant[b]) begin
                    found = 1'b1;
                end else begin
                    lz = lz + 6'd1;
                end
            end
        end
        r      = v;
        r.mant = v.mant << lz;
        r.exp  = v.exp - $signed({5'd0, lz});
        return r;
    endfunction

    // round to nearest even and pack
    function automatic logic [31:0] fp_round(fmm_ifp_t v);
        logic [47:0] m;
        logic [10:0] sh;
        logic        st0;
        logic [23:0] q;
        logic        g;
        logic        st;
        logic        inc;
        logic [7:0]  base;
        logic [30:0] mag;
        logic [31:0] r;
        m   = v.mant;
        st0 = 1'b0;
        sh  = 11'd0;
        if (v.exp < 11'sd1) begin
            sh   = 11'(11'sd1 - v.exp);
            base = 8'd0;
            if (sh >= 11'd48) begin
                st0 = |m;
                m   = 48'd0;
            end else begin
                st0 = |(m & ~({48{1'b1}} << sh));
                m   = m >> sh;
            end
        end else begin
            base = 8'(v.exp - 11'sd1);
        end
        q   = m[47:24];
        g   = m[23];
        st  = (|m[22:0]) | st0;
        inc = g & (st | q[0]);
        mag = {base, 23'd0} + {7'd0, q} + {30'd0, inc};
        if (v.nan) begin
            r = CANON_NAN;
        end else if (v.inf || (v.exp >= 11'sd255)) begin
            r = {v.sign, 8'hFF, 23'd0};
        end else if (v.mant == 48'd0) begin
            r = {v.sign, 31'd0};
        end else begin
            r = {v.sign, mag};
        end
        return r;
    endfunction

endpackage

### rtl/core/fmm_ram.sv
module fmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/fmm_datapath.sv
module fmm_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fmm_pkg::fmm_cmd_t                  ctl,
    output fmm_pkg::fmm_sts_t                  sts,
    input  logic [fmm_pkg::IDX_W-1:0]          s_row,
    input  logic [fmm_pkg::IDX_W-1:0]          s_col,
    input  logic [fmm_pkg::FP_W-1:0]           s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fmm_pkg::IDX_W-1:0]          m_row,
    output logic [fmm_pkg::IDX_W-1:0]          m_col,
    output logic [fmm_pkg::FP_W-1:0]           m_product,
    output logic                               m_last
);
    import fmm_pkg::*;

    logic [FP_W-1:0]     a_q;
    logic [FP_W-1:0]     b_q;
    logic [STORE_AW-1:0] waddr;

    fmm_ifp_t        mpre_reg;
    fmm_aln_t        aln_reg;
    fmm_ifp_t        sum_reg;
    fmm_ifp_t        nrm_reg;
    logic [FP_W-1:0] rnd;
    logic [FP_W-1:0] prod_reg;
    logic [FP_W-1:0] acc_reg;
    logic [FP_W-1:0] lane_reg [4];
    logic [FP_W-1:0] opx;
    logic [FP_W-1:0] opy;
    logic [FP_W-1:0] lane_rd;

    logic                 m_valid_reg;
    logic [IDX_W-1:0]     m_row_reg;
    logic [IDX_W-1:0]     m_col_reg;
    logic [FP_W-1:0]      m_product_reg;
    logic                 m_last_reg;

    assign waddr = {s_row, s_col};

    fmm_ram #(.WIDTH(FP_W), .DEPTH(STORE_DEPTH)) u_left (
        .aclk (aclk),
        .we   (ctl.wr_a),
        .waddr(waddr),
        .wdata(s_value),
        .raddr({ctl.ri, ctl.k}),
        .rdata(a_q)
    );

    fmm_ram #(.WIDTH(FP_W), .DEPTH(STORE_DEPTH)) u_right (
        .aclk (aclk),
        .we   (ctl.wr_b),
        .waddr(waddr),
        .wdata(s_value),
        .raddr({ctl.rj, ctl.k}),
        .rdata(b_q)
    );

    // operand select: lane plus product, or lane combine
    assign lane_rd = lane_reg[ctl.lane];
    always_comb begin
        if (ctl.fin) begin
            opx = ctl.fin_first ? lane_reg[0] : acc_reg;
            opy = lane_rd;
        end else begin
            opx = lane_rd;
            opy = prod_reg;
        end
    end

    assign rnd = fp_round(nrm_reg);

    always_ff @(posedge aclk) begin
        mpre_reg <= fp_mul(a_q, b_q);
        aln_reg  <= fp_align(opx, opy);
        sum_reg  <= fp_sum(aln_reg);
        nrm_reg  <= fp_norm(ctl.nsel_sum ? sum_reg : mpre_reg);
        if (ctl.wr_prod) begin
            prod_reg <= rnd;
        end
        if (ctl.wr_acc) begin
            acc_reg <= rnd;
        end
        if (ctl.clr) begin
            for (int l = 0; l < 4; l++) begin
                lane_reg[l] <= '0;
            end
        end else if (ctl.wr_lane) begin
            lane_reg[ctl.lane] <= rnd;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            m_row_reg     <= ctl.ri;
            m_col_reg     <= ctl.rj;
            m_product_reg <= acc_reg;
            m_last_reg    <= ctl.last;
        end
    end

    assign sts.out_busy = m_valid_reg & ~m_ready;
    assign m_valid      = m_valid_reg;
    assign m_row        = m_row_reg;
    assign m_col        = m_col_reg;
    assign m_product    = m_product_reg;
    assign m_last       = m_last_reg;

endmodule

### rtl/core/fmm_ctrl.sv
module fmm_ctrl #(
    parameter int MATRIX_SIZE = fmm_pkg::DEF_MATRIX_SIZE
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [fmm_pkg::IDX_W-1:0]  s_row,
    input  logic [fmm_pkg::IDX_W-1:0]  s_col,
    output fmm_pkg::fmm_cmd_t          ctl,
    input  fmm_pkg::fmm_sts_t          sts
);
    import fmm_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_SIZE - 1);
    localparam logic [IDX_W:0]   SIZE     = (IDX_W + 1)'(MATRIX_SIZE);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_MNRM = 4'd3;
    localparam logic [3:0] S_MRND = 4'd4;
    localparam logic [3:0] S_ALN  = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_ANRM = 4'd7;
    localparam logic [3:0] S_ARND = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             fin_reg, fin_next;
    logic [1:0]       step_reg, step_next;
    logic             in_range;
    logic             accept;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid & s_ready;
    assign in_range = ({1'b0, s_row} < SIZE) && ({1'b0, s_col} < SIZE);

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        fin_next   = fin_reg;
        step_next  = step_reg;

        ctl           = '0;
        ctl.ri        = i_reg;
        ctl.rj        = j_reg;
        ctl.k         = k_reg;
        ctl.fin       = fin_reg;
        ctl.fin_first = (step_reg == 2'd0);
        ctl.lane      = fin_reg ? LANE_W'(step_reg + 2'd1) : k_reg[LANE_W-1:0];
        ctl.last      = (i_reg == LAST_IDX) && (j_reg == LAST_IDX);

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ctl.wr_a = (s_cmd == CMD_LOAD_A) && in_range;
                    ctl.wr_b = (s_cmd == CMD_LOAD_B) && in_range;
                    if (s_cmd == CMD_COMPUTE) begin
                        ctl.clr    = 1'b1;
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        fin_next   = 1'b0;
                        step_next  = 2'd0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_MNRM;
            S_MNRM: state_next = S_MRND;
            S_MRND: begin
                ctl.wr_prod = 1'b1;
                state_next  = S_ALN;
            end
            S_ALN:  state_next = S_SUM;
            S_SUM:  state_next = S_ANRM;
            S_ANRM: begin
                ctl.nsel_sum = 1'b1;
                state_next   = S_ARND;
            end
            S_ARND: begin
                if (!fin_reg) begin
                    ctl.wr_lane = 1'b1;
                    if (k_reg == LAST_IDX) begin
                        fin_next   = 1'b1;
                        step_next  = 2'd0;
                        state_next = S_ALN;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_RD;
                    end
                end else begin
                    ctl.wr_acc = 1'b1;
                    if (step_reg == 2'd2) begin
                        state_next = S_EMIT;
                    end else begin
                        step_next  = step_reg + 2'd1;
                        state_next = S_ALN;
                    end
                end
            end
            S_EMIT: begin
                if (!sts.out_busy) begin
                    ctl.emit  = 1'b1;
                    ctl.clr   = 1'b1;
                    k_next    = '0;
                    fin_next  = 1'b0;
                    step_next = 2'd0;
                    if (ctl.last) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_RD;
                        if (j_reg == LAST_IDX) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            fin_reg   <= 1'b0;
            step_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            fin_reg   <= fin_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/core/float_matrix_multiply_transposed_top.sv
// single-precision matrix multiply C = A * B^T for MATRIX_SIZE x MATRIX_SIZE
// matrices. a request with cmd 0 or 1 writes one element of A or B (ignored
// when row or col is out of range); cmd 2 walks every product element (i,j)
// in row-major order and emits it on the m_ side, tlast on the final one;
// cmd 3 is dropped. every dot product term goes through store read,
// multiply, normalize, round, align, add, normalize and round on the one
// shared float unit, and the four lanes are combined in 3 more adds before
// the result is handed to the output register; no new request is accepted
// until a compute has emitted its final element. products follow binary32
// round-to-nearest-even with full subnormal support; nan results come out
// as 0x7FC00000. reading an element that was never loaded gives an
// arbitrary value.
module float_matrix_multiply_transposed_top #(
    parameter int MATRIX_SIZE = fmm_pkg::DEF_MATRIX_SIZE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[1:0], row[4:2], col[7:5], value[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], product[37:6], zero[39:38]
    output logic        m_tlast
);
    import fmm_pkg::*;

    fmm_cmd_t         ctl;
    fmm_sts_t         sts;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic [FP_W-1:0]  product;

    // sequencer: request decode and loop counters
    fmm_ctrl #(.MATRIX_SIZE(MATRIX_SIZE)) u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_tvalid),
        .s_ready(s_tready),
        .s_cmd  (s_tdata[1:0]),
        .s_row  (s_tdata[4:2]),
        .s_col  (s_tdata[7:5]),
        .ctl    (ctl),
        .sts    (sts)
    );

    // stores, float unit, lane accumulators and output register
    fmm_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .sts      (sts),
        .s_row    (s_tdata[4:2]),
        .s_col    (s_tdata[7:5]),
        .s_value  (s_tdata[39:8]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_row    (out_row),
        .m_col    (out_col),
        .m_product(product),
        .m_last   (m_tlast)
    );

    assign m_tdata = {2'b00, product, out_col, out_row};

    // the final element carries the last row and column
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            (m_tdata[2:0] == IDX_W'(MATRIX_SIZE - 1)) &&
            (m_tdata[5:3] == IDX_W'(MATRIX_SIZE - 1)))
        else $error("tlast on a non-final element");

    // stores are written only from an accepted request
    a_wr_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.wr_a || ctl.wr_b) |-> (s_tvalid && s_tready))
        else $error("store write without accepted request");

    // the round stage feeds one destination at a time
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.wr_prod, ctl.wr_lane, ctl.wr_acc, ctl.emit}))
        else $error("conflicting datapath writes");

    // a handed-off result shows up on the output
    a_emit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |=> m_tvalid)
        else $error("emitted result not presented");

endmodule

### tb/float_matrix_multiply_transposed_top_tb.sv
module float_matrix_multiply_transposed_top_tb;
    import fmm_pkg::*;

    localparam int          N          = DEF_MATRIX_SIZE;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          HOLD_LONG  = 3000;
    localparam int          RAND_ITEMS = 16;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        glance_ok;
        logic [31:0] glance;
    } request_t;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic [31:0] product;
        logic        last;
    } element_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    logic [31:0] left_bits  [STORE_DEPTH];
    logic [31:0] right_bits [STORE_DEPTH];
    element_t    pending_products [$];

    int errors      = 0;
    int loads       = 0;
    int computes    = 0;
    int ignored     = 0;
    int compared    = 0;
    int sink_wait   = 0;
    int sink_hold   = 0;

    // extremes and special values; first compute sees all-zero matrices
    request_t directed_rows [16] = '{
        '{CMD_UNUSED,  3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h0000_0000},
        '{CMD_LOAD_A,  3'd0, 3'd0, 32'h3F80_0000, 1'b0, 32'h0},
        '{CMD_LOAD_B,  3'd0, 3'd0, 32'h7F80_0000, 1'b0, 32'h0},
        '{CMD_LOAD_A,  3'd1, 3'd1, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{CMD_LOAD_B,  3'd2, 3'd2, 32'h0000_0001, 1'b0, 32'h0},
        '{CMD_LOAD_A,  3'd2, 3'd2, 32'h3F80_0000, 1'b0, 32'h0},
        '{CMD_LOAD_A,  3'd3, 3'd3, 32'h7F7F_FFFF, 1'b0, 32'h0},
        '{CMD_LOAD_B,  3'd3, 3'd3, 32'h7F7F_FFFF, 1'b0, 32'h0},
        '{CMD_LOAD_A,  3'd4, 3'd4, 32'h8000_0000, 1'b0, 32'h0},
        '{CMD_LOAD_B,  3'd5, 3'd6, 32'h807F_FFFF, 1'b0, 32'h0},
        '{CMD_LOAD_A,  3'd7, 3'd7, 32'hFF80_0000, 1'b0, 32'h0},
        '{CMD_LOAD_B,  3'd7, 3'd0, 32'hC000_0000, 1'b0, 32'h0},
        '{CMD_COMPUTE, 3'd5, 3'd2, 32'hDEAD_BEEF, 1'b0, 32'h0},
        '{CMD_UNUSED,  3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
        '{CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0}
    };

    float_matrix_multiply_transposed_top #(.MATRIX_SIZE(N)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // binary32 arithmetic, round to nearest even, subnormals kept
    function automatic logic is_nan32(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf32(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic [63:0] sig32(logic [31:0] x);
        return {40'd0, (x[30:23] != 8'd0), x[22:0]};
    endfunction

    function automatic int exp32(logic [31:0] x);
        return ((x[30:23] == 8'd0) ? 1 : int'(x[30:23])) - 150;
    endfunction

    // value = m * 2^e, exact apart from a jammed lsb
    function automatic logic [31:0] round_pack(logic s, logic [63:0] m, int e);
        int          p;
        int          qe;
        int          sh;
        logic [63:0] q;
        logic        g;
        logic        st;
        if (m == 64'd0) return {s, 31'd0};
        p = 63;
        while (!m[p]) p--;
        qe = p + e - 23;
        if (qe < -149) qe = -149;
        sh = qe - e;
        if (sh > 64) begin
            q = 64'd0;
            g = 1'b0;
            st = 1'b1;
        end else if (sh > 0) begin
            q  = m >> sh;
            g  = m[sh-1];
            st = |(m << (65 - sh));
        end else begin
            q  = m << (-sh);
            g  = 1'b0;
            st = 1'b0;
        end
        if (g && (st || q[0])) q = q + 64'd1;
        if (q[24]) begin
            q  = q >> 1;
            qe = qe + 1;
        end
        if (q[23]) begin
            if (qe + 150 >= 255) return {s, 8'hFF, 23'd0};
            return {s, 8'(qe + 150), q[22:0]};
        end
        return {s, 8'd0, q[22:0]};
    endfunction

    function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan32(a) || is_nan32(b) || (is_inf32(a) && a[30:0] != 0 && b[30:0] == 0)
            || (is_inf32(b) && a[30:0] == 0))
            return CANON_NAN;
        if (is_inf32(a) || is_inf32(b)) return {s, 8'hFF, 23'd0};
        return round_pack(s, sig32(a) * sig32(b), exp32(a) + exp32(b));
    endfunction

    function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mh;
        logic [63:0] ml;
        logic [63:0] m;
        int          ea;
        int          eb;
        int          eh;
        int          d;
        logic        a_hi;
        logic        st;
        logic        s;
        if (is_nan32(a) || is_nan32(b) || (is_inf32(a) && is_inf32(b) && a[31] != b[31]))
            return CANON_NAN;
        if (is_inf32(a)) return a;
        if (is_inf32(b)) return b;
        // 30 guard bits keep the jammed sticky below the rounding point
        ma   = sig32(a) << 30;
        mb   = sig32(b) << 30;
        ea   = exp32(a) - 30;
        eb   = exp32(b) - 30;
        a_hi = (ea > eb) || ((ea == eb) && (ma >= mb));
        mh   = a_hi ? ma : mb;
        ml   = a_hi ? mb : ma;
        eh   = a_hi ? ea : eb;
        d    = a_hi ? ea - eb : eb - ea;
        if (d >= 64) begin
            st = (ml != 64'd0);
            ml = 64'd0;
        end else begin
            st = |(ml << (64 - d));
            if (d == 0) st = 1'b0;
            ml = ml >> d;
        end
        ml = ml | {63'd0, st};
        if (a[31] == b[31]) begin
            m = mh + ml;
            s = a[31];
        end else begin
            m = mh - ml;
            s = (m == 64'd0) ? 1'b0 : (a_hi ? a[31] : b[31]);
        end
        return round_pack(s, m, eh);
    endfunction

    // element (i,j): row i of A against row j of B in four lanes
    function automatic logic [31:0] dot_product_bits(int i, int j);
        logic [31:0] lane [4];
        logic [31:0] total;
        for (int l = 0; l < 4; l++) lane[l] = 32'h0;
        for (int k = 0; k < N; k++)
            lane[k % 4] = add32(lane[k % 4], mul32(left_bits[i*8+k], right_bits[j*8+k]));
        total = add32(lane[0], lane[1]);
        total = add32(total, lane[2]);
        return add32(total, lane[3]);
    endfunction

    // mostly ordinary magnitudes so sums cancel and round, some specials
    function automatic logic [31:0] draw_value();
        logic [31:0] specials [8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                      32'h7FC0_0001, 32'h0000_0001, 32'h7F7F_FFFF,
                                      32'h0080_0000};
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return specials[$urandom_range(0, 7)];
            2:       return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
        endcase
    endfunction

    // one request through the slave side, with a random gap ahead of it
    task automatic send_request(request_t rq);
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {rq.value, rq.col, rq.row, rq.cmd};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        case (rq.cmd)
            CMD_LOAD_A: begin
                left_bits[rq.row*8 + rq.col] = rq.value;
                loads++;
            end
            CMD_LOAD_B: begin
                right_bits[rq.row*8 + rq.col] = rq.value;
                loads++;
            end
            CMD_COMPUTE: begin
                computes++;
                for (int i = 0; i < N; i++)
                    for (int j = 0; j < N; j++)
                        pending_products.push_back('{3'(i), 3'(j),
                            rq.glance_ok ? rq.glance : dot_product_bits(i, j),
                            (i == N-1) && (j == N-1)});
            end
            default: ignored++;
        endcase
    endtask

    // receiver readiness, redrawn after each product and a long hold on request
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_wait > 0) begin
            m_tready <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        element_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_products.size() == 0) begin
                $error("product with nothing pending: tdata %h tlast %b", m_tdata, m_tlast);
                errors++;
            end else begin
                want = pending_products.pop_front();
                compared++;
                if (m_tdata[2:0] !== want.out_row) begin
                    $error("out_row expected %0d actual %0d", want.out_row, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[5:3] !== want.out_col) begin
                    $error("out_col expected %0d actual %0d", want.out_col, m_tdata[5:3]);
                    errors++;
                end
                if (m_tdata[37:6] !== want.product) begin
                    $error("product expected %h actual %h", want.product, m_tdata[37:6]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last expected %b actual %b", want.last, m_tlast);
                    errors++;
                end
            end
            sink_wait <= $urandom_range(0, 3);
        end
    end

    initial begin
        request_t rq;
        int       sent;
        int       burst;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 40'd0;
        m_tready = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // every element written before any compute reads it
        for (int e = 0; e < 2 * STORE_DEPTH; e++) begin
            rq = '{(e < STORE_DEPTH) ? CMD_LOAD_A : CMD_LOAD_B,
                   3'((e % STORE_DEPTH) / 8), 3'(e % 8), 32'h0, 1'b0, 32'h0};
            send_request(rq);
        end

        foreach (directed_rows[r]) send_request(directed_rows[r]);

        // load bursts closed by a compute, plus unused commands as noise
        sent = 0;
        while (sent < RAND_ITEMS) begin
            burst = $urandom_range(3, 14);
            for (int b = 0; b < burst; b++) begin
                if ($urandom_range(0, 19) == 0)
                    rq = '{CMD_UNUSED, 3'($urandom), 3'($urandom), $urandom, 1'b0, 32'h0};
                else
                    rq = '{2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom),
                           draw_value(), 1'b0, 32'h0};
                send_request(rq);
                sent++;
            end
            // sender pause until the sink has drained everything
            if (computes == 4) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                wait (pending_products.size() == 0);
            end
            rq = '{CMD_COMPUTE, 3'($urandom), 3'($urandom), $urandom, 1'b0, 32'h0};
            send_request(rq);
            sent++;
            // sink stalls for a long stretch while loads keep coming
            if (computes == 4) sink_hold = HOLD_LONG;
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        wait (pending_products.size() == 0);
        repeat (100) @(posedge aclk);
        $display("covered %0d loads, %0d compute and %0d unused requests;", loads, computes,
                 ignored);
        $display("%0d product elements compared against the soft-float predictor", compared);
        if (errors == 0) begin
            $display("float_matrix_multiply_transposed_top verification clean");
        end else begin
            $display("float_matrix_multiply_transposed_top verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("float_matrix_multiply_transposed_top verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/fmm_pkg.sv
rtl/core/fmm_ram.sv
rtl/core/fmm_datapath.sv
rtl/core/fmm_ctrl.sv
rtl/core/float_matrix_multiply_transposed_top.sv
tb/float_matrix_multiply_transposed_top_tb.sv
